/* design/imu_frame_scaler_with_fault_count_core_assert.svh */
// assertion macros for the imu frame scaler checker
`ifndef IMU_FRAME_SCALER_WITH_FAULT_COUNT_CORE_ASSERT_SVH
`define IMU_FRAME_SCALER_WITH_FAULT_COUNT_CORE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define IMUFS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("imufs assertion failed");

// next-cycle implication, off while reset is low
`define IMUFS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("imufs assertion failed");

`endif

/* design/imufs_pkg.sv */
// types and constants of the imu frame scaler
`default_nettype none

package imufs_pkg;

    typedef logic signed [15:0] t_raw;

    typedef struct packed {
        t_raw ax;
        t_raw ay;
        t_raw az;
        t_raw temp;
        t_raw gx;
        t_raw gy;
        t_raw gz;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NUM,
        B_DIV,
        B_SIGN,
        B_OUT
    } t_back_state;

    typedef enum logic [2:0] {
        CH_AX   = 3'd0,
        CH_AY   = 3'd1,
        CH_AZ   = 3'd2,
        CH_TEMP = 3'd3,
        CH_GX   = 3'd4,
        CH_GY   = 3'd5,
        CH_GZ   = 3'd6
    } t_chan;

    // position of the last byte of a frame
    localparam logic [3:0] LastPos = 4'd13;

    localparam logic signed [26:0] ScaleMilli = 27'sd1000;
    localparam logic signed [26:0] TempGain   = 27'sd50;
    localparam logic signed [26:0] TempOffset = 27'sd621010;

    // reciprocals for floor(n / d) = (n * ceil(2^33 / d)) >> 33, exact for n < 2^25
    localparam int unsigned    RecipShift = 33;
    localparam logic [28:0]    RecipAccel = 29'd524288;
    localparam logic [28:0]    RecipGyro  = 29'd65572020;
    localparam logic [28:0]    RecipTemp  = 29'd505290271;

    localparam logic signed [15:0] GyroFaultMax = 16'sd32750;
    localparam logic [7:0]         FaultSat     = 8'd255;
    localparam logic [7:0]         LimitReset   = 8'd10;

    function automatic logic gyro_fault(input t_raw v);
        return (v > GyroFaultMax) || (v < -GyroFaultMax);
    endfunction

endpackage

`default_nettype wire

/* design/imufs_if.sv */
// handshake channels of the imu frame scaler
`default_nettype none

interface imufs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] fault_limit;
    modport source (output valid, output fault_limit, input ready);
    modport sink   (input valid, input fault_limit, output ready);
endinterface

interface imufs_res_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] accel_x_milli;
    logic signed [11:0] accel_y_milli;
    logic signed [11:0] accel_z_milli;
    logic signed [18:0] temp_milli;
    logic signed [18:0] gyro_x_milli;
    logic signed [18:0] gyro_y_milli;
    logic signed [18:0] gyro_z_milli;
    logic               frame_valid;
    logic [7:0]         fault_count;
    modport source (
        output valid, output accel_x_milli, output accel_y_milli, output accel_z_milli,
        output temp_milli, output gyro_x_milli, output gyro_y_milli, output gyro_z_milli,
        output frame_valid, output fault_count, input ready
    );
    modport sink (
        input valid, input accel_x_milli, input accel_y_milli, input accel_z_milli,
        input temp_milli, input gyro_x_milli, input gyro_y_milli, input gyro_z_milli,
        input frame_valid, input fault_count, output ready
    );
endinterface

`default_nettype wire

/* design/imu_frame_scaler_with_fault_count_core.sv */
// top level of the imu frame scaler with consecutive fault count
//
//  channel   dir  handshake      payload
//  i_rx      in   valid/ready    rx_byte, 8 bit
//  i_cfg     in   valid/ready    fault_limit, 8 bit, ready always high
//  o_res     out  valid/ready    seven scaled channels, frame_valid, fault_count
//
// the collector takes one byte per cycle; the 14th byte pushes a frame into the queue
// the scaling engine works one channel at a time in numerator, divide and sign steps on its
// shared multipliers; a frame passes pop, those steps for each of the seven channels, load
// the last byte of a frame stalls while the queue is full; the engine stalls
// while the output register holds an untaken result
// synchronous active-low reset clears position, queue, state and fault count, and sets the fault limit to 10
`default_nettype none

module imu_frame_scaler_with_fault_count_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imufs_byte_if.sink  i_rx,
    imufs_cfg_if.sink   i_cfg,
    imufs_res_if.source o_res
);
    import imufs_pkg::*;

    logic [7:0] r_limit;
    logic       push;
    logic       pop;
    t_frame     push_frame;
    t_frame     pop_frame;
    t_q_flags   q_flags;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.fault_limit;
        end
    end

    imufs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_q_flags (q_flags),
        .o_push    (push),
        .o_frame   (push_frame)
    );

    imufs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_frame),
        .i_pop   (pop),
        .o_data  (pop_frame),
        .o_flags (q_flags)
    );

    imufs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fault_limit (r_limit),
        .i_q_flags     (q_flags),
        .i_frame       (pop_frame),
        .o_pop         (pop),
        .o_res         (o_res)
    );

endmodule

`default_nettype wire

/* design/imufs_front.sv */
// byte collector: gathers 14 bytes and pushes one raw frame
`default_nettype none

module imufs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    imufs_byte_if.sink         i_rx,
    input  imufs_pkg::t_q_flags i_q_flags,
    output logic               o_push,
    output imufs_pkg::t_frame  o_frame
);
    import imufs_pkg::*;

    logic [7:0] r_store [13];
    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic       last;
    logic       take;

    // position past the end counts as frame end too
    assign last       = (r_pos >= LastPos);
    assign i_rx.ready = !(last && i_q_flags.full);
    assign take       = i_rx.valid && i_rx.ready;
    assign o_push     = take && last;

    assign o_frame.ax   = t_raw'({r_store[0],  r_store[1]});
    assign o_frame.ay   = t_raw'({r_store[2],  r_store[3]});
    assign o_frame.az   = t_raw'({r_store[4],  r_store[5]});
    assign o_frame.temp = t_raw'({r_store[6],  r_store[7]});
    assign o_frame.gx   = t_raw'({r_store[8],  r_store[9]});
    assign o_frame.gy   = t_raw'({r_store[10], r_store[11]});
    assign o_frame.gz   = t_raw'({r_store[12], i_rx.rx_byte});

    always_comb begin
        n_pos = r_pos;
        if (take) begin
            n_pos = last ? 4'd0 : r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !last) begin
            r_store[r_pos] <= i_rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

/* design/imufs_queue.sv */
// short frame queue between the collector and the scaling engine
`default_nettype none

module imufs_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  imufs_pkg::t_frame   i_data,
    input  logic                i_pop,
    output imufs_pkg::t_frame   o_data,
    output imufs_pkg::t_q_flags o_flags
);
    import imufs_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_frame          r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_flags.full  = (r_cnt == CntFull);
    assign o_flags.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_flags.full;
    assign do_pop        = i_pop && !o_flags.empty;
    assign o_data        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/imufs_back.sv */
// scaling engine: one channel at a time through shared multipliers
`default_nettype none

module imufs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_fault_limit,
    input  imufs_pkg::t_q_flags i_q_flags,
    input  imufs_pkg::t_frame   i_frame,
    output logic                o_pop,
    imufs_res_if.source         o_res
);
    import imufs_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    t_chan              r_ch;
    t_frame             r_frame;
    logic signed [26:0] r_num;
    logic [18:0]        r_q;
    logic               r_neg;
    logic signed [18:0] r_res [7];
    logic [7:0]         r_fault_cnt;
    logic [7:0]         r_cnt_res;
    logic               r_valid_res;
    logic               r_out_valid;

    logic               ld_num;
    logic               ld_q;
    logic               ld_res;
    logic               ld_out;

    t_raw               sel_raw;
    logic signed [26:0] sel_ext;
    logic signed [26:0] gain;
    logic signed [26:0] offset;
    logic signed [26:0] n_num;
    logic [24:0]        mag;
    logic [28:0]        recip;
    logic [53:0]        prod;
    logic signed [18:0] q_s;
    logic               fault;
    logic [7:0]         n_fault_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_q_flags.empty) n_state = B_NUM;
            B_NUM:   n_state = B_DIV;
            B_DIV:   n_state = B_SIGN;
            B_SIGN:  n_state = (r_ch == CH_GZ) ? B_OUT : B_NUM;
            B_OUT:   if (!r_out_valid || o_res.ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        ld_num = 1'b0;
        ld_q   = 1'b0;
        ld_res = 1'b0;
        ld_out = 1'b0;
        unique case (r_state)
            B_IDLE:  o_pop  = !i_q_flags.empty;
            B_NUM:   ld_num = 1'b1;
            B_DIV:   ld_q   = 1'b1;
            B_SIGN:  ld_res = 1'b1;
            B_OUT:   ld_out = !r_out_valid || o_res.ready;
            default: o_pop  = 1'b0;
        endcase
    end

    // channel select and numerator
    always_comb begin
        unique case (r_ch)
            CH_AX:   sel_raw = r_frame.ax;
            CH_AY:   sel_raw = r_frame.ay;
            CH_AZ:   sel_raw = r_frame.az;
            CH_TEMP: sel_raw = r_frame.temp;
            CH_GX:   sel_raw = r_frame.gx;
            CH_GY:   sel_raw = r_frame.gy;
            default: sel_raw = r_frame.gz;
        endcase
        unique case (r_ch) inside
            CH_AX, CH_AY, CH_AZ: recip = RecipAccel;
            CH_TEMP:             recip = RecipTemp;
            default:             recip = RecipGyro;
        endcase
    end

    assign sel_ext = 27'(sel_raw);
    assign gain    = (r_ch == CH_TEMP) ? TempGain : ScaleMilli;
    assign offset  = (r_ch == CH_TEMP) ? TempOffset : 27'sd0;
    assign n_num   = sel_ext * gain + offset;

    // divide magnitude by reciprocal multiply, sign restored afterwards
    assign mag  = r_num[26] ? 25'(-r_num) : 25'(r_num);
    assign prod = 54'(mag) * 54'(recip);
    assign q_s  = $signed(r_q);

    assign fault = gyro_fault(i_frame.gx) || gyro_fault(i_frame.gy) || gyro_fault(i_frame.gz);

    always_comb begin
        n_fault_cnt = 8'd0;
        if (fault) begin
            n_fault_cnt = (r_fault_cnt == FaultSat) ? r_fault_cnt : r_fault_cnt + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_ch        <= CH_AX;
            r_fault_cnt <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_ch        <= CH_AX;
                r_fault_cnt <= n_fault_cnt;
            end else if (ld_res && r_ch != CH_GZ) begin
                r_ch <= t_chan'(r_ch + 3'd1);
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame     <= i_frame;
            r_cnt_res   <= n_fault_cnt;
            r_valid_res <= (n_fault_cnt <= i_fault_limit);
        end
        if (ld_num) begin
            r_num <= n_num;
        end
        if (ld_q) begin
            r_q   <= 19'(prod >> RecipShift);
            r_neg <= r_num[26];
        end
        if (ld_res) begin
            r_res[r_ch] <= r_neg ? -q_s : q_s;
        end
        if (ld_out) begin
            o_res.accel_x_milli <= 12'(r_res[CH_AX]);
            o_res.accel_y_milli <= 12'(r_res[CH_AY]);
            o_res.accel_z_milli <= 12'(r_res[CH_AZ]);
            o_res.temp_milli    <= r_res[CH_TEMP];
            o_res.gyro_x_milli  <= r_res[CH_GX];
            o_res.gyro_y_milli  <= r_res[CH_GY];
            o_res.gyro_z_milli  <= r_res[CH_GZ];
            o_res.frame_valid   <= r_valid_res;
            o_res.fault_count   <= r_cnt_res;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

`default_nettype wire

/* design/imufs_sva.sv */
// port-level checker for the imu frame scaler, bound to the top level
`default_nettype none

`include "imu_frame_scaler_with_fault_count_core_assert.svh"

module imufs_sva (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic signed [11:0] i_accel_x,
    input logic signed [18:0] i_gyro_x,
    input logic signed [18:0] i_gyro_y,
    input logic signed [18:0] i_gyro_z,
    input logic               i_frame_valid,
    input logic [7:0]         i_fault_count
);
    logic clean;
    logic stalled;
    logic gyro_in_range;

    assign clean   = i_res_valid && (i_fault_count == 8'd0);
    assign stalled = i_res_valid && !i_res_ready;

    // a clean frame keeps every scaled gyro value within the fault bound scaled to milli units
    assign gyro_in_range = (i_gyro_x <= 19'sd250000) && (i_gyro_x >= -19'sd250000)
                        && (i_gyro_y <= 19'sd250000) && (i_gyro_y >= -19'sd250000)
                        && (i_gyro_z <= 19'sd250000) && (i_gyro_z >= -19'sd250000);

    `IMUFS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, stalled, i_res_valid && $stable({i_fault_count, i_gyro_x}))
    `IMUFS_ASSERT_IMPL(a_clean_is_valid, i_clk, i_rst_n, clean, i_frame_valid)
    `IMUFS_ASSERT_IMPL(a_clean_gyro, i_clk, i_rst_n, clean, gyro_in_range)
    `IMUFS_ASSERT_IMPL(a_accel_floor, i_clk, i_rst_n, i_res_valid, i_accel_x >= -12'sd2000)

endmodule

bind imu_frame_scaler_with_fault_count_core imufs_sva u_imufs_sva (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_accel_x     (o_res.accel_x_milli),
    .i_gyro_x      (o_res.gyro_x_milli),
    .i_gyro_y      (o_res.gyro_y_milli),
    .i_gyro_z      (o_res.gyro_z_milli),
    .i_frame_valid (o_res.frame_valid),
    .i_fault_count (o_res.fault_count)
);

`default_nettype wire
